[rtl/gfdd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfdd_pkg: shared definitions for the gyro flick classifier
// Register indexes, reset values, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package gfdd_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   localparam int THRESH_W    = 16;
   localparam int THRESH_SQ_W = 2 * THRESH_W;
   localparam int AXIS_W      = 15;
   localparam int COUNT_W     = 8;
   localparam int QUIET_W     = 4;
   localparam int PROD_W      = AXIS_W + COUNT_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_THRESH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_THRESH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_THRESH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BURST    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BURST    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_NEEDED = 3'd5;

   // Reset values; thresholds are kept squared.
   localparam logic [THRESH_SQ_W-1:0] START_SQ_RST     = 32'd774400; // 880 squared
   localparam logic [THRESH_SQ_W-1:0] END_SQ_RST       = 32'd102400; // 320 squared
   localparam logic [AXIS_W-1:0]      AXIS_THRESH_RST  = 15'd240;
   localparam logic [COUNT_W-1:0]     MIN_BURST_RST    = 8'd5;
   localparam logic [COUNT_W-1:0]     MAX_BURST_RST    = 8'd60;
   localparam logic [QUIET_W-1:0]     QUIET_NEEDED_RST = 4'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [QUIET_W-1:0] QUIET_MAX = 4'd15;

   typedef struct packed {
      logic [THRESH_SQ_W-1:0] start_sq;
      logic [THRESH_SQ_W-1:0] end_sq;
      logic [AXIS_W-1:0]      axis_thresh;
      logic [COUNT_W-1:0]     min_burst;
      logic [COUNT_W-1:0]     max_burst;
      logic [QUIET_W-1:0]     quiet_needed;
   } gfdd_cfg_type;

endpackage
`default_nettype wire

[rtl/gfdd_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfdd_ifs: channel interfaces of the gyro flick classifier
// Sample request channel, symbol response channel and register write channel.
// ----------------------------------------------------------------------------
interface gfdd_req_if
   import gfdd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] rate_x;
   logic signed [SAMPLE_BITS-1:0] rate_y;
   logic signed [SAMPLE_BITS-1:0] rate_z;

   modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
   modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gfdd_rsp_if;
   logic valid;
   logic ready;
   logic symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface gfdd_csr_if
   import gfdd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/gfdd_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfdd_csr: configuration registers
// Holds the six settings; the two magnitude thresholds are stored squared.
// ----------------------------------------------------------------------------
module gfdd_csr
   import gfdd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   gfdd_csr_if.sink    csr_chan,
   output gfdd_cfg_type cfg
);

   gfdd_cfg_type cfg_ff, cfg_in;
   logic [THRESH_SQ_W-1:0] data_sq;

   assign csr_chan.ready = 1'b1;
   assign data_sq = THRESH_SQ_W'(csr_chan.data) * THRESH_SQ_W'(csr_chan.data);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_START_THRESH: cfg_in.start_sq     = data_sq;
            CSR_END_THRESH:   cfg_in.end_sq       = data_sq;
            CSR_AXIS_THRESH:  cfg_in.axis_thresh  = csr_chan.data[AXIS_W-1:0];
            CSR_MIN_BURST:    cfg_in.min_burst    = csr_chan.data[COUNT_W-1:0];
            CSR_MAX_BURST:    cfg_in.max_burst    = csr_chan.data[COUNT_W-1:0];
            CSR_QUIET_NEEDED: cfg_in.quiet_needed = csr_chan.data[QUIET_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_sq     <= START_SQ_RST;
         cfg_ff.end_sq       <= END_SQ_RST;
         cfg_ff.axis_thresh  <= AXIS_THRESH_RST;
         cfg_ff.min_burst    <= MIN_BURST_RST;
         cfg_ff.max_burst    <= MAX_BURST_RST;
         cfg_ff.quiet_needed <= QUIET_NEEDED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/gfdd_mag.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfdd_mag: squared-magnitude stage
// Registers the sum of the three squared rates along with the Z rate.
// ----------------------------------------------------------------------------
module gfdd_mag
   import gfdd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] rate_x,
   input  wire logic signed [SAMPLE_BITS-1:0] rate_y,
   input  wire logic signed [SAMPLE_BITS-1:0] rate_z,
   output logic                               out_valid,
   output logic [2*SAMPLE_BITS+1:0]           mag2,
   output logic signed [SAMPLE_BITS-1:0]      out_rate_z
);

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int MAG_W = SQ_W + 2;

   logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
   logic [MAG_W-1:0] mag2_in, mag2_ff;
   logic signed [SAMPLE_BITS-1:0] rate_z_ff;
   logic valid_ff, valid_in;

   assign sq_x = rate_x * rate_x;
   assign sq_y = rate_y * rate_y;
   assign sq_z = rate_z * rate_z;
   // Squares are never negative, so they extend with zeros.
   assign mag2_in = MAG_W'(unsigned'(sq_x)) + MAG_W'(unsigned'(sq_y))
                  + MAG_W'(unsigned'(sq_z));
   assign valid_in = en ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff   <= mag2_in;
         rate_z_ff <= rate_z;
      end
   end

   assign out_valid  = valid_ff;
   assign mag2       = mag2_ff;
   assign out_rate_z = rate_z_ff;

endmodule
`default_nettype wire

[rtl/gfdd_burst.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfdd_burst: burst tracker and symbol decision
// Keeps the burst state and drives the response register.
// ----------------------------------------------------------------------------
module gfdd_burst
   import gfdd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [2*SAMPLE_BITS+1:0]      mag2,
   input  wire logic signed [SAMPLE_BITS-1:0] rate_z,
   input  wire gfdd_cfg_type                  cfg,
   output logic                               rsp_valid,
   output logic                               rsp_symbol
);

   localparam int SUM_W = SAMPLE_BITS + 8;
   localparam int MAG_W = 2 * SAMPLE_BITS + 2;
   localparam int CMP_W = (MAG_W > THRESH_SQ_W) ? MAG_W : THRESH_SQ_W;
   localparam int ABS_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;

   logic                     in_burst_ff, in_burst_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [QUIET_W-1:0]       quiet_ff, quiet_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     symbol_ff, symbol_in;

   logic                     start_hit, is_quiet, close, pass, emit;
   logic signed [SUM_W-1:0]  z_ext, sum_new;
   logic [SUM_W-1:0]         sum_abs;
   logic [COUNT_W-1:0]       count_new;
   logic [QUIET_W-1:0]       quiet_new;
   logic [PROD_W-1:0]        prod;

   assign start_hit = CMP_W'(mag2) > CMP_W'(cfg.start_sq);
   assign is_quiet  = CMP_W'(mag2) < CMP_W'(cfg.end_sq);

   assign z_ext     = {{(SUM_W-SAMPLE_BITS){rate_z[SAMPLE_BITS-1]}}, rate_z};
   assign sum_new   = sum_ff + z_ext;
   assign sum_abs   = sum_new[SUM_W-1] ? unsigned'(-sum_new) : unsigned'(sum_new);
   assign count_new = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
   assign quiet_new = !is_quiet ? '0 :
                      ((quiet_ff == QUIET_MAX) ? quiet_ff : quiet_ff + QUIET_W'(1));
   assign prod      = PROD_W'(cfg.axis_thresh) * PROD_W'(count_new);

   assign close = (quiet_new >= cfg.quiet_needed) || (count_new >= cfg.max_burst);
   assign pass  = (count_new >= cfg.min_burst) && (ABS_W'(sum_abs) > ABS_W'(prod));

   always_comb begin
      in_burst_in = in_burst_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      quiet_in    = quiet_ff;
      emit        = 1'b0;
      if (en && in_valid) begin
         if (!in_burst_ff) begin
            if (start_hit) begin
               in_burst_in = 1'b1;
               sum_in      = z_ext;
               count_in    = COUNT_W'(1);
               quiet_in    = '0;
            end
         end else if (close) begin
            in_burst_in = 1'b0;
            sum_in      = '0;
            count_in    = '0;
            quiet_in    = '0;
            emit        = pass;
         end else begin
            sum_in   = sum_new;
            count_in = count_new;
            quiet_in = quiet_new;
         end
      end
   end

   // A passing burst has a nonzero sum, so the sign bit alone picks the symbol.
   assign rsp_valid_in = en ? emit : rsp_valid_ff;
   assign symbol_in    = emit ? !sum_new[SUM_W-1] : symbol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_burst_ff  <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         quiet_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_burst_ff  <= in_burst_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         quiet_ff     <= quiet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = symbol_ff;

`ifndef SYNTHESIS
   a_count_tracks_burst: assert property (@(posedge clock) disable iff (reset)
      in_burst_ff == (count_ff != '0))
      else $error("sample count disagrees with burst state");

   a_idle_is_clear: assert property (@(posedge clock) disable iff (reset)
      !in_burst_ff |-> (sum_ff == '0) && (quiet_ff == '0))
      else $error("burst state not cleared while idle");

   a_symbol_ends_burst: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_burst_ff) && !in_burst_ff)
      else $error("symbol issued without closing a burst");
`endif

endmodule
`default_nettype wire

[rtl/gyro_flick_dot_dash_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_flick_dot_dash_classifier: gyro flick to dot/dash symbol detector
// Opens a burst on a strong rotation, sums its Z rate and, when a long enough
// burst ends with enough average Z rate, reports a dot or a dash.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake     | payload
//   ----------+-----------+---------------+-----------------------------------
//   req_chan  | in        | valid / ready | rate_x, rate_y, rate_z (signed)
//   rsp_chan  | out       | valid / ready | symbol (0 dot, 1 dash)
//   csr_chan  | in        | valid / ready | index, data (register write)
//
// A request is taken every cycle while the response register is free or being
// taken; the request that closes a burst passes the magnitude register, then
// its symbol is set in the response register. Throughput is one request per
// cycle. When a symbol waits untaken, the two-stage pipeline freezes and req
// ready drops until it is taken. Register writes are always ready and take
// effect on the next cycle. Synchronous reset idles the burst tracker,
// empties the pipeline and restores the register defaults.
//
module gyro_flick_dot_dash_classifier
   import gfdd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   gfdd_req_if.sink   req_chan,
   gfdd_rsp_if.source rsp_chan,
   gfdd_csr_if.sink   csr_chan
);

   // Pipeline advance: the response register is empty or its symbol is taken.
   logic en;
   logic rsp_valid;
   logic rsp_symbol;
   gfdd_cfg_type cfg;

   logic                          s1_valid;
   logic [2*SAMPLE_BITS+1:0]      s1_mag2;
   logic signed [SAMPLE_BITS-1:0] s1_rate_z;

   assign en             = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.symbol = rsp_symbol;

   // Register file; the two magnitude thresholds are squared as they are written.
   gfdd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // First stage: squared magnitude of the accepted sample.
   gfdd_mag #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mag (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_chan.valid),
      .rate_x     (req_chan.rate_x),
      .rate_y     (req_chan.rate_y),
      .rate_z     (req_chan.rate_z),
      .out_valid  (s1_valid),
      .mag2       (s1_mag2),
      .out_rate_z (s1_rate_z)
   );

   // Second stage: burst tracking, the closing test and the response register.
   gfdd_burst #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_burst (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s1_valid),
      .mag2       (s1_mag2),
      .rate_z     (s1_rate_z),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol)
   );

endmodule
`default_nettype wire
